// ===== rtl/core/cts_pkg.sv =====
// Shared types, constants and character-class functions for the C subset token scanner.
package cts_pkg;

  localparam int POSITION_WIDTH  = 16;
  localparam int KEYWORD_MAX_LEN = 8;
  localparam int KW_IDX_W        = $clog2(KEYWORD_MAX_LEN);
  localparam int KW_COUNT        = 14;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_IDENT   = 5'd2;
  localparam logic [4:0] KIND_PUNCT   = 5'd3;
  localparam logic [4:0] KIND_INVALID = 5'd4;
  localparam logic [4:0] KIND_KW_BASE = 5'd5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Keyword text is right-aligned: the first character sits in the highest used byte.
  localparam logic [KEYWORD_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    "if", "else", "while", "for", "switch", "case", "break",
    "continue", "return", "sizeof", "char", "short", "int", "struct"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd4, 4'd5, 4'd8, 4'd6, 4'd6, 4'd4, 4'd5, 4'd3, 4'd6
  };

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM_POS,
    MODE_NUM_NEG,
    MODE_IDENT,
    MODE_PEND
  } scan_mode_t;

  typedef logic [KEYWORD_MAX_LEN-1:0][7:0] kw_buf_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } byte_beat_t;

  typedef struct packed {
    logic [4:0]         token_kind;
    logic [15:0]        token_start;
    logic [15:0]        token_length;
    logic signed [63:0] number_value;
    logic [7:0]         punct_first;
    logic [7:0]         punct_second;
    logic               last_result;
  } token_beat_t;

  // Up to two result beats produced by one source byte.
  typedef struct packed {
    logic [1:0]  count;
    token_beat_t first;
    token_beat_t second;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_pend_char(input logic [7:0] c);
    return (c == CH_EQ) || (c == CH_MINUS) || (c == CH_AMP) || (c == CH_BAR) ||
           (c == CH_BANG);
  endfunction

  function automatic logic is_pair(input logic [7:0] p, input logic [7:0] c);
    return ((p == CH_EQ) && (c == CH_EQ)) || ((p == CH_MINUS) && (c == CH_GT)) ||
           ((p == CH_AMP) && (c == CH_AMP)) || ((p == CH_BAR) && (c == CH_BAR)) ||
           ((p == CH_BANG) && (c == CH_EQ));
  endfunction

  function automatic logic [4:0] word_kind(input kw_buf_t buffer, input logic [15:0] len);
    logic [4:0]                   kind;
    logic                         hit;
    logic [KEYWORD_MAX_LEN*8-1:0] text;
    kind = KIND_IDENT;
    if (len <= 16'(KEYWORD_MAX_LEN)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        hit = (len == 16'(KW_LEN[i]));
        // Move the text up so that its first character sits in the top byte.
        text = KW_TEXT[i] << (8 * (KEYWORD_MAX_LEN - int'(KW_LEN[i])));
        for (int k = 0; k < KEYWORD_MAX_LEN; k++) begin
          if ((k < int'(KW_LEN[i])) &&
              (buffer[k] != text[(KEYWORD_MAX_LEN - 1 - k) * 8 +: 8])) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          kind = 5'(KIND_KW_BASE + 5'(i));
        end
      end
    end
    return kind;
  endfunction

endpackage

// ===== rtl/core/cts_scan_core.sv =====
// Scanner state registers and the per-byte classify and accumulate step.
module cts_scan_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  cts_pkg::byte_beat_t beat,
  output cts_pkg::step_t      step
);

  cts_pkg::scan_mode_t                  mode, mode_next;
  logic [cts_pkg::POSITION_WIDTH-1:0]   position, position_next;
  logic [cts_pkg::POSITION_WIDTH-1:0]   start_offset, start_offset_next;
  logic [15:0]                          run_length, run_length_next;
  logic [63:0]                          accumulator, accumulator_next;
  cts_pkg::kw_buf_t                     kw_buffer, kw_buffer_next;
  logic [7:0]                           pending_byte, pending_byte_next;

  logic [7:0]           c;
  logic [63:0]          digit;
  logic [15:0]          run_grown;
  logic                 flush_valid;
  logic                 second_valid;
  logic                 first_valid;
  logic                 do_start;
  cts_pkg::token_beat_t flush_tok;
  cts_pkg::token_beat_t second_tok;

  assign c = beat.char_byte;
  // The digits sit at 0x30..0x39, so the low nibble is the digit value.
  assign digit = 64'(c[3:0]);
  assign run_grown = (run_length != 16'hFFFF) ? run_length + 16'd1 : run_length;

  always_comb begin
    flush_tok = '0;
    flush_valid = 1'b0;
    flush_tok.token_start = 16'(start_offset);
    flush_tok.token_length = run_length;
    case (mode)
      cts_pkg::MODE_NUM_POS: begin
        flush_valid = 1'b1;
        flush_tok.token_kind = cts_pkg::KIND_NUMBER;
        flush_tok.number_value = $signed(accumulator);
      end
      cts_pkg::MODE_NUM_NEG: begin
        flush_valid = 1'b1;
        flush_tok.token_kind = cts_pkg::KIND_NUMBER;
        flush_tok.number_value = $signed(64'd0 - accumulator);
      end
      cts_pkg::MODE_IDENT: begin
        flush_valid = 1'b1;
        flush_tok.token_kind = cts_pkg::word_kind(kw_buffer, run_length);
      end
      cts_pkg::MODE_PEND: begin
        flush_valid = 1'b1;
        flush_tok.token_kind = (pending_byte == cts_pkg::CH_BAR) ? cts_pkg::KIND_INVALID
                                                                 : cts_pkg::KIND_PUNCT;
        flush_tok.token_length = 16'd1;
        flush_tok.punct_first = pending_byte;
      end
      default: begin
        flush_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_next = mode;
    position_next = position + 1'b1;
    start_offset_next = start_offset;
    run_length_next = run_length;
    accumulator_next = accumulator;
    kw_buffer_next = kw_buffer;
    pending_byte_next = pending_byte;
    second_tok = '0;
    second_valid = 1'b0;
    first_valid = 1'b0;
    do_start = 1'b0;

    if (beat.end_of_input) begin
      first_valid = flush_valid;
      second_valid = 1'b1;
      second_tok.token_kind = cts_pkg::KIND_END;
      second_tok.token_start = 16'(position);
      mode_next = cts_pkg::MODE_IDLE;
      position_next = '0;
      start_offset_next = '0;
      run_length_next = '0;
      accumulator_next = '0;
      pending_byte_next = '0;
    end else begin
      case (mode)
        cts_pkg::MODE_NUM_POS, cts_pkg::MODE_NUM_NEG: begin
          if (cts_pkg::is_digit(c)) begin
            accumulator_next = (accumulator << 3) + (accumulator << 1) + digit;
            run_length_next = run_grown;
          end else begin
            first_valid = 1'b1;
            do_start = 1'b1;
          end
        end
        cts_pkg::MODE_IDENT: begin
          if (cts_pkg::is_word(c)) begin
            if (run_length < 16'(cts_pkg::KEYWORD_MAX_LEN)) begin
              kw_buffer_next[run_length[cts_pkg::KW_IDX_W-1:0]] = c;
            end
            run_length_next = run_grown;
          end else begin
            first_valid = 1'b1;
            do_start = 1'b1;
          end
        end
        cts_pkg::MODE_PEND: begin
          if (cts_pkg::is_pair(pending_byte, c)) begin
            second_valid = 1'b1;
            second_tok.token_kind = cts_pkg::KIND_PUNCT;
            second_tok.token_start = 16'(start_offset);
            second_tok.token_length = 16'd2;
            second_tok.punct_first = pending_byte;
            second_tok.punct_second = c;
            mode_next = cts_pkg::MODE_IDLE;
          end else if ((pending_byte == cts_pkg::CH_MINUS) && cts_pkg::is_digit(c)) begin
            mode_next = cts_pkg::MODE_NUM_NEG;
            accumulator_next = digit;
            run_length_next = 16'd2;
          end else begin
            first_valid = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      if (do_start) begin
        mode_next = cts_pkg::MODE_IDLE;
        if (!cts_pkg::is_space(c)) begin
          start_offset_next = position;
          run_length_next = 16'd1;
          if (cts_pkg::is_digit(c)) begin
            mode_next = cts_pkg::MODE_NUM_POS;
            accumulator_next = digit;
          end else if (cts_pkg::is_alpha(c) || (c == cts_pkg::CH_UNDER)) begin
            mode_next = cts_pkg::MODE_IDENT;
            kw_buffer_next[0] = c;
          end else if (cts_pkg::is_pend_char(c)) begin
            mode_next = cts_pkg::MODE_PEND;
            pending_byte_next = c;
          end else begin
            second_valid = 1'b1;
            second_tok.token_start = 16'(position);
            second_tok.token_length = 16'd1;
            second_tok.punct_first = c;
            case (c)
              8'h2B, 8'h2A, 8'h2F, 8'h28, 8'h25, 8'h29, 8'h7B, 8'h7D, 8'h3B, 8'h2C,
              8'h2E: begin
                second_tok.token_kind = cts_pkg::KIND_PUNCT;
              end
              default: begin
                second_tok.token_kind = cts_pkg::KIND_INVALID;
              end
            endcase
          end
        end
      end
    end
  end

  // The final beat of a byte carries the last flag; the flushed token goes first.
  always_comb begin
    step = '0;
    step.count = 2'(first_valid) + 2'(second_valid);
    if (first_valid) begin
      step.first = flush_tok;
      step.first.last_result = !second_valid;
      step.second = second_tok;
      step.second.last_result = 1'b1;
    end else begin
      step.first = second_tok;
      step.first.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cts_pkg::MODE_IDLE;
      position <= '0;
      start_offset <= '0;
      run_length <= '0;
      accumulator <= '0;
      pending_byte <= '0;
    end else if (accept) begin
      mode <= mode_next;
      position <= position_next;
      start_offset <= start_offset_next;
      run_length <= run_length_next;
      accumulator <= accumulator_next;
      pending_byte <= pending_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kw_buffer <= kw_buffer_next;
    end
  end

endmodule

// ===== rtl/core/cts_result_queue.sv =====
// Small shifting result queue that takes up to two beats per cycle and sends one unless stalled.
module cts_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cts_pkg::step_t       step,
  output logic                 almost_full,
  output logic                 valid,
  input  logic                 stall,
  output cts_pkg::token_beat_t head
);

  cts_pkg::token_beat_t         slot [cts_pkg::RQ_DEPTH];
  cts_pkg::token_beat_t         slot_next [cts_pkg::RQ_DEPTH];
  logic [cts_pkg::RQ_CNT_W-1:0] count, count_next;
  logic [cts_pkg::RQ_CNT_W-1:0] base;
  logic [cts_pkg::RQ_CNT_W-1:0] added;
  logic                         pop;

  assign valid = (count != '0);
  assign head = slot[0];
  assign pop = valid && !stall;
  // Room for two beats must remain so that any byte can be taken.
  assign almost_full = (count > cts_pkg::RQ_CNT_W'(cts_pkg::RQ_DEPTH - 2));

  assign base = count - cts_pkg::RQ_CNT_W'(pop);
  assign added = push ? cts_pkg::RQ_CNT_W'(step.count) : '0;
  assign count_next = base + added;

  always_comb begin
    for (int i = 0; i < cts_pkg::RQ_DEPTH; i++) begin
      slot_next[i] = slot[i];
    end
    if (pop) begin
      for (int i = 0; i < cts_pkg::RQ_DEPTH - 1; i++) begin
        slot_next[i] = slot[i + 1];
      end
    end
    for (int i = 0; i < cts_pkg::RQ_DEPTH; i++) begin
      if ((added != '0) && (cts_pkg::RQ_CNT_W'(i) == base)) begin
        slot_next[i] = step.first;
      end
      if ((added == cts_pkg::RQ_CNT_W'(2)) &&
          (cts_pkg::RQ_CNT_W'(i) == base + cts_pkg::RQ_CNT_W'(1))) begin
        slot_next[i] = step.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < cts_pkg::RQ_DEPTH; i++) begin
      slot[i] <= slot_next[i];
    end
  end

endmodule

// ===== rtl/core/c_subset_token_scanner_unit.sv =====
// Top level of the C subset token scanner: scan core feeding the result queue.
// The beats caused by a byte are registered in the queue before they leave it.
// Most tokens close only when the following byte arrives, so they come one byte late.
// Throughput: one byte per cycle; up to two result beats per byte, one sent per cycle
// unless token_stall is set; the input stalls while the four-entry result queue holds
// three or more beats. Reset clears the scanner state and empties the queue at once.
module c_subset_token_scanner_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  cts_pkg::byte_beat_t  byte_data,
  output logic                 token_valid,
  input  logic                 token_stall,
  output cts_pkg::token_beat_t token_data
);

  logic           accept;
  cts_pkg::step_t step;

  assign accept = byte_valid && !byte_stall;

  cts_scan_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (byte_data),
    .step   (step)
  );

  cts_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .step        (step),
    .almost_full (byte_stall),
    .valid       (token_valid),
    .stall       (token_stall),
    .head        (token_data)
  );

endmodule

// ===== tb/tb_c_subset_token_scanner_unit.sv =====
// Self-checking testbench for the C subset token scanner: directed table, long run, random text.
module tb_c_subset_token_scanner_unit;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int          DIR_ROWS    = 26;
  localparam int          LONG_DIGITS = 30;
  localparam int          RANDOM_ITEMS = 1400;

  typedef struct packed {
    cts_pkg::byte_beat_t  beat;
    logic                 typed;
    cts_pkg::token_beat_t want;
  } stim_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eoi;
    logic        typed;
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [7:0]  pf;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_stall;
  cts_pkg::byte_beat_t  byte_data = '0;
  logic                 token_valid;
  logic                 token_stall = 1'b0;
  cts_pkg::token_beat_t token_data;

  c_subset_token_scanner_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_data  (token_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Directed rows; a typed row carries its single expected beat, the others use the predictor.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{8'h00, 1'b0, 1'b1, cts_pkg::KIND_INVALID, 16'd0, 16'd1, 8'h00},
    '{8'hFF, 1'b0, 1'b1, cts_pkg::KIND_INVALID, 16'd1, 16'd1, 8'hFF},
    '{"|",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{8'h09, 1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"-",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"9",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"&",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"&",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"!",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"=",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"=",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{">",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"i",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"f",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"(",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"1",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"x",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"9",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"-",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{">",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{"_",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{8'h00, 1'b1, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{8'h80, 1'b0, 1'b1, cts_pkg::KIND_INVALID, 16'd0, 16'd1, 8'h80},
    '{"{",   1'b0, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00},
    '{8'h00, 1'b1, 1'b0, cts_pkg::KIND_END,     16'd0, 16'd0, 8'h00}
  };

  string kw_words [14] = '{
    "if", "else", "while", "for", "switch", "case", "break",
    "continue", "return", "sizeof", "char", "short", "int", "struct"
  };
  string pair_words [5] = '{"==", "->", "&&", "||", "!="};
  string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string alnum   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string digits  = "0123456789";
  string holders = "=-&|!";
  string singles = "+*/(%){};,.";

  stim_t                stim_q [$];
  cts_pkg::token_beat_t tok_expect [$];
  cts_pkg::token_beat_t step_toks [$];
  int                   gen_count = 0;
  int                   send_idx = 0;
  int                   burst_left = 8;
  int                   gap_left = 0;
  int                   n_fail = 0;
  int unsigned          cyc_count = 0;
  int unsigned          rx_cyc = 0;
  int                   rx_left = 0;
  int                   long_hold = 0;
  rx_pattern_t          rx_style = RX_OPEN;

  // Predictor state.
  cts_pkg::scan_mode_t sc_mode;
  logic [15:0]         sc_pos;
  logic [15:0]         sc_start;
  logic [15:0]         sc_len;
  logic [63:0]         sc_acc;
  logic [7:0]          sc_buf [8];
  logic [7:0]          sc_pend;

  function automatic logic in_set(logic [7:0] c, string s);
    for (int i = 0; i < s.len(); i++) begin
      if (c == s[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic num_ch(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic blank_ch(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic pair_ok(logic [7:0] p, logic [7:0] c);
    return ((p == "=") && (c == "=")) || ((p == "-") && (c == ">")) ||
           ((p == "&") && (c == "&")) || ((p == "|") && (c == "|")) ||
           ((p == "!") && (c == "="));
  endfunction

  function automatic logic [4:0] word_token_kind();
    logic hit;
    if (sc_len > 16'd8) return cts_pkg::KIND_IDENT;
    for (int i = 0; i < 14; i++) begin
      if (16'(kw_words[i].len()) == sc_len) begin
        hit = 1'b1;
        for (int k = 0; k < kw_words[i].len(); k++) begin
          if (sc_buf[k] != kw_words[i][k]) hit = 1'b0;
        end
        if (hit) return 5'(cts_pkg::KIND_KW_BASE + 5'(i));
      end
    end
    return cts_pkg::KIND_IDENT;
  endfunction

  task automatic push_tok(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                          logic [63:0] val, logic [7:0] p1, logic [7:0] p2);
    cts_pkg::token_beat_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.number_value = val;
    t.punct_first  = p1;
    t.punct_second = p2;
    t.last_result  = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic clear_scan();
    sc_mode  = cts_pkg::MODE_IDLE;
    sc_pos   = '0;
    sc_start = '0;
    sc_len   = '0;
    sc_acc   = '0;
    sc_pend  = '0;
  endtask

  task automatic close_token();
    case (sc_mode)
      cts_pkg::MODE_NUM_POS: begin
        push_tok(cts_pkg::KIND_NUMBER, sc_start, sc_len, sc_acc, 8'h00, 8'h00);
      end
      cts_pkg::MODE_NUM_NEG: begin
        push_tok(cts_pkg::KIND_NUMBER, sc_start, sc_len, 64'd0 - sc_acc, 8'h00, 8'h00);
      end
      cts_pkg::MODE_IDENT: begin
        push_tok(word_token_kind(), sc_start, sc_len, 64'd0, 8'h00, 8'h00);
      end
      cts_pkg::MODE_PEND: begin
        push_tok((sc_pend == "|") ? cts_pkg::KIND_INVALID : cts_pkg::KIND_PUNCT,
                 sc_start, 16'd1, 64'd0, sc_pend, 8'h00);
      end
      default: ;
    endcase
    sc_mode = cts_pkg::MODE_IDLE;
  endtask

  task automatic open_token(logic [7:0] c);
    if (!blank_ch(c)) begin
      sc_start = sc_pos;
      sc_len   = 16'd1;
      if (num_ch(c)) begin
        sc_mode = cts_pkg::MODE_NUM_POS;
        sc_acc  = 64'(c - 8'h30);
      end else if (in_set(c, letters)) begin
        sc_mode   = cts_pkg::MODE_IDENT;
        sc_buf[0] = c;
      end else if (in_set(c, holders)) begin
        sc_mode = cts_pkg::MODE_PEND;
        sc_pend = c;
      end else if (in_set(c, singles)) begin
        push_tok(cts_pkg::KIND_PUNCT, sc_pos, 16'd1, 64'd0, c, 8'h00);
      end else begin
        push_tok(cts_pkg::KIND_INVALID, sc_pos, 16'd1, 64'd0, c, 8'h00);
      end
    end
  endtask

  task automatic scan_step(cts_pkg::byte_beat_t b);
    logic [7:0] c;
    c = b.char_byte;
    step_toks.delete();
    if (b.end_of_input) begin
      close_token();
      push_tok(cts_pkg::KIND_END, sc_pos, 16'd0, 64'd0, 8'h00, 8'h00);
      clear_scan();
    end else begin
      case (sc_mode)
        cts_pkg::MODE_NUM_POS, cts_pkg::MODE_NUM_NEG: begin
          if (num_ch(c)) begin
            sc_acc = sc_acc * 64'd10 + 64'(c - 8'h30);
            if (sc_len != 16'hFFFF) sc_len++;
          end else begin
            close_token();
            open_token(c);
          end
        end
        cts_pkg::MODE_IDENT: begin
          if (in_set(c, alnum)) begin
            if (sc_len < 16'd8) sc_buf[sc_len[2:0]] = c;
            if (sc_len != 16'hFFFF) sc_len++;
          end else begin
            close_token();
            open_token(c);
          end
        end
        cts_pkg::MODE_PEND: begin
          if (pair_ok(sc_pend, c)) begin
            push_tok(cts_pkg::KIND_PUNCT, sc_start, 16'd2, 64'd0, sc_pend, c);
            sc_mode = cts_pkg::MODE_IDLE;
          end else if ((sc_pend == "-") && num_ch(c)) begin
            // A minus right before a digit turns into the sign of the number.
            sc_mode = cts_pkg::MODE_NUM_NEG;
            sc_acc  = 64'(c - 8'h30);
            sc_len  = 16'd2;
          end else begin
            close_token();
            open_token(c);
          end
        end
        default: open_token(c);
      endcase
      sc_pos = sc_pos + 16'd1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_result = 1'b1;
  endtask

  task automatic add_item(logic [7:0] c, logic eoi);
    stim_t st;
    st = '0;
    st.beat.char_byte    = c;
    st.beat.end_of_input = eoi;
    stim_q.push_back(st);
    gen_count++;
  endtask

  function automatic logic [7:0] pick_from(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] blank_pick();
    logic [7:0] c;
    c = 8'($urandom_range(8, 13));
    return (c == 8'h08) ? 8'h20 : c;
  endfunction

  // Mostly well-formed C-like text with random content, some noise and end markers.
  task automatic gen_random(int target);
    int stop_at, next_end, n, k;
    stop_at  = gen_count + target;
    next_end = gen_count + $urandom_range(20, 80);
    while (gen_count < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          n = $urandom_range(0, 13);
          for (k = 0; k < kw_words[n].len(); k++) add_item(kw_words[n][k], 1'b0);
          if ($urandom_range(0, 4) == 0) add_item(pick_from(alnum), 1'b0);
        end
        3, 4, 5: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
          add_item(pick_from(letters), 1'b0);
          for (k = 1; k < n; k++) add_item(pick_from(alnum), 1'b0);
        end
        6, 7, 8, 9, 10: begin
          if ($urandom_range(0, 1) == 0) add_item("-", 1'b0);
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(18, 25) : $urandom_range(1, 6);
          for (k = 0; k < n; k++) add_item(pick_from(digits), 1'b0);
        end
        11, 12: begin
          n = $urandom_range(0, 4);
          add_item(pair_words[n][0], 1'b0);
          add_item(pair_words[n][1], 1'b0);
        end
        13, 14: add_item(pick_from(holders), 1'b0);
        15, 16: add_item(pick_from(singles), 1'b0);
        default: begin
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++) add_item(8'($urandom_range(0, 255)), 1'b0);
        end
      endcase
      if ($urandom_range(0, 9) < 6) add_item(blank_pick(), 1'b0);
      if (gen_count >= next_end) begin
        add_item(8'($urandom_range(0, 255)), 1'b1);
        next_end = gen_count + $urandom_range(20, 80);
      end
    end
    add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic string fmt_tok(cts_pkg::token_beat_t t);
    return $sformatf("kind %0d start %0d len %0d value %0d first %h second %h last %b",
                     t.token_kind, t.token_start, t.token_length, t.number_value,
                     t.punct_first, t.punct_second, t.last_result);
  endfunction

  // Sender, predictor and checker share one process so a beat is predicted before it is seen.
  always @(posedge clk) begin
    stim_t                cur;
    cts_pkg::token_beat_t want;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        cur = stim_q[send_idx];
        scan_step(cur.beat);
        if (cur.typed) begin
          tok_expect.push_back(cur.want);
        end else begin
          foreach (step_toks[i]) tok_expect.push_back(step_toks[i]);
        end
        send_idx++;
      end

      if (token_valid && !token_stall) begin
        if (tok_expect.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected token beat: %s", fmt_tok(token_data));
        end else begin
          want = tok_expect.pop_front();
          if ((token_data.token_kind !== want.token_kind) ||
              (token_data.token_start !== want.token_start) ||
              (token_data.token_length !== want.token_length) ||
              (token_data.number_value !== want.number_value) ||
              (token_data.punct_first !== want.punct_first) ||
              (token_data.punct_second !== want.punct_second) ||
              (token_data.last_result !== want.last_result)) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("token mismatch");
              $display("  expected %s", fmt_tok(want));
              $display("  actual   %s", fmt_tok(token_data));
            end
          end
        end
      end

      if (!byte_valid || !byte_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_valid <= 1'b0;
        end else if (send_idx < stim_q.size()) begin
          byte_valid <= 1'b1;
          byte_data  <= stim_q[send_idx].beat;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
          end
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls on changing patterns, with a regularly repeated long hold-off.
  always @(posedge clk) begin
    logic hold_now;
    if (rst) begin
      token_stall <= 1'b0;
    end else begin
      rx_cyc++;
      if (rx_cyc % 1024 == 700) long_hold = 160;
      if (long_hold > 0) begin
        long_hold--;
        hold_now = 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_style = rx_pattern_t'($urandom_range(0, 3));
          rx_left  = $urandom_range(16, 160);
        end
        rx_left--;
        case (rx_style)
          RX_OPEN:  hold_now = 1'b0;
          RX_HALF:  hold_now = 1'($urandom_range(0, 1));
          RX_HEAVY: hold_now = ($urandom_range(0, 3) != 0);
          default:  hold_now = (rx_cyc % 5 == 0);
        endcase
      end
      token_stall <= hold_now;
    end
  end

  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count >= CYCLE_LIMIT) begin
      $display("tb_c_subset_token_scanner_unit: FAIL");
      $finish;
    end
  end

  initial begin
    stim_t st;
    clear_scan();
    foreach (sc_buf[i]) sc_buf[i] = '0;
    foreach (dir_tab[i]) begin
      st = '0;
      st.beat.char_byte      = dir_tab[i].ch;
      st.beat.end_of_input   = dir_tab[i].eoi;
      st.typed               = dir_tab[i].typed;
      st.want.token_kind     = dir_tab[i].kind;
      st.want.token_start    = dir_tab[i].start;
      st.want.token_length   = dir_tab[i].len;
      st.want.punct_first    = dir_tab[i].pf;
      st.want.last_result    = 1'b1;
      stim_q.push_back(st);
    end
    // One number long enough to wrap the 64-bit accumulator.
    for (int i = 0; i < LONG_DIGITS; i++) add_item("9", 1'b0);
    add_item(" ", 1'b0);
    add_item("q", 1'b0);
    add_item(8'h00, 1'b1);
    gen_random(RANDOM_ITEMS);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (!((send_idx == stim_q.size()) && !byte_valid && (tok_expect.size() == 0)))
      @(posedge clk);
    repeat (16) @(posedge clk);
    if ((n_fail == 0) && (tok_expect.size() == 0)) begin
      $display("tb_c_subset_token_scanner_unit: PASS");
    end else begin
      $display("tb_c_subset_token_scanner_unit: FAIL");
    end
    $finish;
  end

endmodule
